[design/alkc_pkg.sv]
package alkc_pkg;

  // line buffer capacity, one slot is kept free
  localparam int unsigned LINE_CAPACITY = 40;

  // keyword set
  localparam int unsigned KEY_COUNT    = 7;
  localparam int unsigned KEY_MAX      = 20;
  localparam int unsigned KEY_BITS     = KEY_MAX * 8;
  localparam int unsigned WINDOW_DEPTH = KEY_MAX - 1;

  // payload widths
  localparam int unsigned CLASS_W   = 3;
  localparam int unsigned OUT_LEN_W = 6;
  localparam int unsigned DUR_W     = 16;

  localparam logic [DUR_W-1:0] ALARM_DURATION_RST = DUR_W'(5000);
  localparam logic [DUR_W-1:0] TICK_MAX           = '1;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  // operation codes of an input beat
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // keyword slots, bit positions of the seen vector
  typedef enum int unsigned {
    KEY_LOCKOUT   = 0,
    KEY_LOCK_DONE = 1,
    KEY_TAMPER    = 2,
    KEY_PWR_FAIL  = 3,
    KEY_FAILURE   = 4,
    KEY_BREACH    = 5,
    KEY_RESTORED  = 6
  } key_e;

  // line classes
  typedef enum logic [CLASS_W-1:0] {
    CLS_LOCKOUT   = 3'd0,
    CLS_LOCK_DONE = 3'd1,
    CLS_TAMPER    = 3'd2,
    CLS_FAILURE   = 3'd3,
    CLS_RESTORED  = 3'd4,
    CLS_OTHER     = 3'd5
  } class_e;

  // keyword text, right aligned: byte 0 is the last character
  localparam logic [KEY_BITS-1:0] KEY_TEXT [KEY_COUNT] = '{
    KEY_BITS'("LOCKOUT MAX ATTEMPTS"),
    KEY_BITS'("LOCKOUT FINISHED"),
    KEY_BITS'("TAMPER"),
    KEY_BITS'("POWER FAIL"),
    KEY_BITS'("FAILURE"),
    KEY_BITS'("BREACH"),
    KEY_BITS'("POWER RESTORED")
  };

  localparam int unsigned KEY_LEN [KEY_COUNT] = '{20, 16, 6, 10, 7, 6, 14};

  // commands to the alarm timer for one processed beat
  typedef struct packed {
    logic tick;
    logic start;
    logic stop;
  } alarm_cmd_t;

endpackage

[design/alkc_chan_if.sv]
interface alkc_in_if;
  import alkc_pkg::*;

  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, operation, rx_byte, input ready);
  modport sink (input valid, operation, rx_byte, output ready);
endinterface

interface alkc_out_if;
  import alkc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 line_done;
  logic [CLASS_W-1:0]   line_class;
  logic [OUT_LEN_W-1:0] line_length;
  logic                 alarm;

  modport source (output valid, line_done, line_class, line_length, alarm, input ready);
  modport sink (input valid, line_done, line_class, line_length, alarm, output ready);
endinterface

interface alkc_cfg_if;
  import alkc_pkg::*;

  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[design/alkc_match.sv]
module alkc_match #(
  parameter int unsigned LineCapacity = alkc_pkg::LINE_CAPACITY
) (
  input  logic [7:0]                          byte_i,
  input  logic [7:0]                          win_i [alkc_pkg::WINDOW_DEPTH],
  input  logic [$clog2(LineCapacity)-1:0]     count_after_i,
  output logic [alkc_pkg::KEY_COUNT-1:0]      hit_o
);
  import alkc_pkg::*;

  localparam int unsigned CntW = $clog2(LineCapacity);

  // per keyword, per window slot character compare
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
    logic [WINDOW_DEPTH-1:0] char_ok;
    logic                    len_ok;
    logic                    last_ok;

    for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_slot
      if (i + 1 < KEY_LEN[k]) begin : g_cmp
        assign char_ok[i] = (KEY_TEXT[k][(i+1)*8 +: 8] == win_i[i]);
      end else begin : g_pad
        assign char_ok[i] = 1'b1;
      end
    end

    // whole keyword must lie inside the current line
    assign len_ok  = (count_after_i >= CntW'(KEY_LEN[k]));
    assign last_ok = (KEY_TEXT[k][7:0] == byte_i);
    assign hit_o[k] = len_ok & last_ok & (&char_ok);
  end

endmodule

[design/alkc_alarm.sv]
module alkc_alarm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  alkc_pkg::alarm_cmd_t       cmd_i,
  input  logic [alkc_pkg::DUR_W-1:0] duration_i,
  output logic                       alarm_o
);
  import alkc_pkg::*;

  logic             alarm_q, alarm_d;
  logic [DUR_W-1:0] elapsed_q, elapsed_d;
  logic [DUR_W-1:0] elapsed_inc;

  // saturating tick count
  assign elapsed_inc = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + DUR_W'(1);

  // next alarm state
  always_comb begin
    alarm_d   = alarm_q;
    elapsed_d = elapsed_q;
    priority if (cmd_i.start) begin
      alarm_d   = 1'b1;
      elapsed_d = '0;
    end else if (cmd_i.stop) begin
      alarm_d   = 1'b0;
      elapsed_d = '0;
    end else if (cmd_i.tick && alarm_q) begin
      if (elapsed_inc >= duration_i) begin
        alarm_d   = 1'b0;
        elapsed_d = '0;
      end else begin
        elapsed_d = elapsed_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q   <= 1'b0;
      elapsed_q <= '0;
    end else begin
      alarm_q   <= alarm_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign alarm_o = alarm_d;

  // ticks only count while the alarm is on
  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !alarm_q |-> elapsed_q == '0)
    else $error("elapsed ticks nonzero with alarm off");

  // start and stop never arrive together, and a tick never comes with either
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.start && cmd_i.stop) && !(cmd_i.tick && (cmd_i.start || cmd_i.stop)))
    else $error("conflicting alarm commands");

endmodule

[design/alert_line_keyword_classifier_unit.sv]
// a beat passes the input beat register and then the result register
// throughput: one byte or tick per cycle while results are taken, set by the single
// input register and result register around the keyword compare and alarm update
// the input side keeps taking beats while a result waits, until both stages fill
// reset: line empty, no keyword seen, alarm off, alarm_duration back to 5000 ticks
module alert_line_keyword_classifier_unit #(
  parameter int unsigned LineCapacity = alkc_pkg::LINE_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  alkc_in_if.sink     in_i,
  alkc_out_if.source  res_o,
  alkc_cfg_if.sink    cfg_i
);
  import alkc_pkg::*;

  localparam int unsigned CntW = $clog2(LineCapacity);
  localparam logic [CntW-1:0] CountMax = CntW'(LineCapacity - 1);

  // handshake and pipeline control
  logic s1_valid_q;
  logic s1_op_q;
  logic [7:0] s1_byte_q;
  logic res_valid_q;
  logic advance, in_fire, proc;

  assign advance     = !res_valid_q || res_o.ready;
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;
  assign proc        = s1_valid_q && advance;
  assign cfg_i.ready = 1'b1;

  // line state
  logic [CntW-1:0]      count_q, count_d;
  logic [KEY_COUNT-1:0] seen_q, seen_d;
  logic                 text_end_q, text_end_d;
  logic [7:0]           win_q [WINDOW_DEPTH];
  logic [DUR_W-1:0]     dur_q;

  logic                 is_byte, is_eol, is_store, eol_done, text_end_now;
  logic [CntW-1:0]      count_after;
  logic [KEY_COUNT-1:0] hits;
  class_e               line_cls;
  alarm_cmd_t           alarm_cmd;
  logic                 alarm_next;

  // beat decode
  assign is_byte      = (op_e'(s1_op_q) == OP_BYTE);
  assign is_eol       = is_byte && ((s1_byte_q == CHAR_LF) || (s1_byte_q == CHAR_CR));
  assign is_store     = is_byte && !is_eol && (count_q < CountMax);
  assign eol_done     = is_eol && (count_q != '0);
  assign count_after  = count_q + CntW'(1);
  assign text_end_now = text_end_q || (s1_byte_q == CHAR_NUL);

  alkc_match #(
    .LineCapacity (LineCapacity)
  ) u_match (
    .byte_i        (s1_byte_q),
    .win_i         (win_q),
    .count_after_i (count_after),
    .hit_o         (hits)
  );

  // classification in priority order
  always_comb begin
    priority if (seen_q[KEY_LOCKOUT])   line_cls = CLS_LOCKOUT;
    else if (seen_q[KEY_LOCK_DONE])     line_cls = CLS_LOCK_DONE;
    else if (seen_q[KEY_TAMPER])        line_cls = CLS_TAMPER;
    else if (seen_q[KEY_PWR_FAIL] || seen_q[KEY_FAILURE] || seen_q[KEY_BREACH])
                                        line_cls = CLS_FAILURE;
    else if (seen_q[KEY_RESTORED])      line_cls = CLS_RESTORED;
    else                                line_cls = CLS_OTHER;
  end

  // next line state
  always_comb begin
    count_d    = count_q;
    seen_d     = seen_q;
    text_end_d = text_end_q;
    if (eol_done) begin
      count_d    = '0;
      seen_d     = '0;
      text_end_d = 1'b0;
    end else if (is_store) begin
      count_d    = count_after;
      text_end_d = text_end_now;
      seen_d     = seen_q | (text_end_now ? '0 : hits);
    end
  end

  // alarm commands
  assign alarm_cmd.tick  = proc && !is_byte;
  assign alarm_cmd.start = proc && eol_done &&
                           ((line_cls == CLS_LOCKOUT) || (line_cls == CLS_TAMPER) ||
                            (line_cls == CLS_FAILURE));
  assign alarm_cmd.stop  = proc && eol_done &&
                           ((line_cls == CLS_LOCK_DONE) || (line_cls == CLS_RESTORED));

  alkc_alarm u_alarm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (alarm_cmd),
    .duration_i (dur_q),
    .alarm_o    (alarm_next)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      count_q     <= '0;
      seen_q      <= '0;
      text_end_q  <= 1'b0;
      dur_q       <= ALARM_DURATION_RST;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (proc) begin
        s1_valid_q <= 1'b0;
      end
      if (proc) begin
        res_valid_q <= 1'b1;
        count_q     <= count_d;
        seen_q      <= seen_d;
        text_end_q  <= text_end_d;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        dur_q <= cfg_i.data;
      end
    end
  end

  // input beat register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= in_i.operation;
      s1_byte_q <= in_i.rx_byte;
    end
  end

  // character window, newest first; slots of an old line are masked by the count check
  always_ff @(posedge clk_i) begin
    if (proc && is_store) begin
      win_q[0] <= s1_byte_q;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_o.line_done   <= eol_done;
      res_o.line_class  <= eol_done ? line_cls : CLS_OTHER;
      res_o.line_length <= eol_done ? OUT_LEN_W'(count_q) : '0;
      res_o.alarm       <= alarm_next;
    end
  end

  assign res_o.valid = res_valid_q;

  // line never grows past its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountMax)
    else $error("stored count beyond capacity");

  // a finished line leaves the buffer empty
  a_line_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && eol_done |=> count_q == '0 && seen_q == '0 && !text_end_q)
    else $error("line state not cleared after line end");

  // keywords and end of text only exist inside a non-empty line
  a_seen_needs_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q != '0 || text_end_q) |-> count_q != '0)
    else $error("line flags set on an empty line");

  // a result without a finished line reports the neutral class and zero length
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_o.line_done |->
      res_o.line_class == CLS_OTHER && res_o.line_length == '0)
    else $error("result fields set without a finished line");

endmodule
